// File: hdl/assert_macros.svh
// Assertion shorthands shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted during reset.
`define CHECK_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, muted during reset.
`define CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: hdl/lcwf_pkg.sv
package lcwf_pkg;

   localparam int SAMPLE_W = 24;
   localparam int WEIGHT_W = 31;
   localparam int FILL_W   = 3;
   localparam int CFG_W    = 16;
   localparam int OP_W     = 2;
   localparam int DIV_DW   = 34;
   localparam int DIV_VW   = 16;
   localparam int PROD_W   = 32;
   localparam int FIFO_DEPTH = 2;

   localparam logic [6:0]       SCALE_CG    = 7'd100;
   localparam logic [CFG_W-1:0] RESET_CPG   = 16'd450;
   localparam logic [CFG_W-1:0] RESET_DBAND = 16'd25;

   localparam logic [OP_W-1:0] OP_FILTER = 2'd0;
   localparam logic [OP_W-1:0] OP_TARE   = 2'd1;
   localparam logic [OP_W-1:0] OP_COMMIT = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

   localparam logic CSR_CPG   = 1'b0;
   localparam logic CSR_DBAND = 1'b1;

   typedef enum logic [1:0] {
      KIND_FILTER,
      KIND_TARE,
      KIND_COMMIT,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic                       zero;
      logic signed [SAMPLE_W-1:0] sample;
   } item_type;

   typedef struct packed {
      logic              start;
      logic [DIV_DW-1:0] dividend;
      logic [DIV_VW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_DW-1:0] quotient;
   } div_rsp_type;

endpackage

// File: hdl/lcwf_div.sv
`include "assert_macros.svh"

module lcwf_div (
   input  logic                 clock,
   input  logic                 reset,
   input  lcwf_pkg::div_req_type req,
   output lcwf_pkg::div_rsp_type rsp
);

   localparam int DW  = lcwf_pkg::DIV_DW;
   localparam int VW  = lcwf_pkg::DIV_VW;
   localparam int CW  = $clog2(DW + 1);

   logic [VW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [VW:0]   shifted;
   logic [VW+1:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[DW-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one restoring step: keep the trial remainder when it did not borrow
         if (!trial[VW+1]) begin
            rem_in = trial[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   `CHECK_NOW(a_no_restart, clock, reset, req.start, !busy_ff)
   `CHECK_NEXT(a_done_ends_busy, clock, reset, done_ff, !busy_ff)

endmodule

// File: hdl/lcwf_front.sv
`include "assert_macros.svh"

module lcwf_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push,
   output logic                                   full,
   input  logic [lcwf_pkg::OP_W-1:0]              op,
   input  logic signed [lcwf_pkg::SAMPLE_W-1:0]   sample,
   output logic                                   head_valid,
   output lcwf_pkg::item_type                     head,
   input  logic                                   take
);

   lcwf_pkg::item_type slot_ff [lcwf_pkg::FIFO_DEPTH];
   lcwf_pkg::item_type incoming;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_take;

   // classify the op code before queueing
   always_comb begin
      case (op)
         lcwf_pkg::OP_FILTER: incoming.kind = lcwf_pkg::KIND_FILTER;
         lcwf_pkg::OP_TARE:   incoming.kind = lcwf_pkg::KIND_TARE;
         lcwf_pkg::OP_COMMIT: incoming.kind = lcwf_pkg::KIND_COMMIT;
         default:             incoming.kind = lcwf_pkg::KIND_NOP;
      endcase
      incoming.zero   = (sample == '0);
      incoming.sample = sample;
   end

   assign full       = (count_ff == 2'(lcwf_pkg::FIFO_DEPTH));
   assign head_valid = (count_ff != 2'd0);
   assign head       = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_take    = take && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_take};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `CHECK_NOW(a_fifo_bound, clock, reset, 1'b1, count_ff <= 2'(lcwf_pkg::FIFO_DEPTH))
   `CHECK_NOW(a_ptr_match, clock, reset, count_ff != 2'd1, wr_ptr_ff == rd_ptr_ff)

endmodule

// File: hdl/lcwf_back.sv
`include "assert_macros.svh"

module lcwf_back #(
   parameter int WD       = 4,
   parameter int TARE_MAX = 15
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  head_valid,
   input  lcwf_pkg::item_type                    head,
   output logic                                  take,
   input  logic [lcwf_pkg::CFG_W-1:0]            cpg,
   input  logic [lcwf_pkg::CFG_W-1:0]            dband,
   input  logic                                  pop,
   output logic                                  out_valid,
   output logic [lcwf_pkg::WEIGHT_W-1:0]         out_weight,
   output logic [lcwf_pkg::FILL_W-1:0]           out_fill,
   output logic                                  out_upd
);

   localparam int SW    = lcwf_pkg::SAMPLE_W;
   localparam int DW    = lcwf_pkg::DIV_DW;
   localparam int VW    = lcwf_pkg::DIV_VW;
   localparam int PW    = lcwf_pkg::PROD_W;
   localparam int PTR_W = $clog2(WD);
   localparam int CNT_W = $clog2(WD + 1);
   localparam int WT_W  = SW + $clog2(WD) + 1;
   localparam int TV_W  = $clog2(TARE_MAX + 1);
   localparam int TT_W  = SW + TV_W + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_AVG_GO, S_AVG_WAIT, S_SCALE, S_WGT_WAIT, S_TARE_WAIT, S_EMIT
   } state_type;

   state_type state_ff, state_in;

   logic signed [SW-1:0]   store_ff [WD];
   logic signed [SW-1:0]   store_in [WD];
   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic signed [WT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic signed [SW-1:0]   offset_ff, offset_in;
   logic signed [TT_W-1:0] tt_ff, tt_in;
   logic [TV_W-1:0]        tv_ff, tv_in;

   logic signed [SW-1:0]   own_ff, own_in;
   logic signed [SW-1:0]   avg_ff, avg_in;
   logic                   sign_ff, sign_in;
   logic [lcwf_pkg::WEIGHT_W-1:0] res_w_ff, res_w_in;
   logic                   res_u_ff, res_u_in;

   logic                   start_ff, start_in;
   logic [DW-1:0]          dvd_ff, dvd_in;
   logic [VW-1:0]          dvs_ff, dvs_in;

   logic                   out_valid_ff, out_valid_in;
   logic [lcwf_pkg::WEIGHT_W-1:0] out_w_ff, out_w_in;
   logic [lcwf_pkg::FILL_W-1:0]   out_f_ff, out_f_in;
   logic                   out_upd_ff, out_upd_in;

   lcwf_pkg::div_req_type  dreq;
   lcwf_pkg::div_rsp_type  drsp;

   logic [WT_W-1:0]        total_mag;
   logic [TT_W-1:0]        tt_mag;
   logic signed [SW:0]     diff;
   logic [SW:0]            diff_mag;
   logic [PW-1:0]          product;
   logic [SW-1:0]          q_low;

   assign dreq.start    = start_ff;
   assign dreq.dividend = dvd_ff;
   assign dreq.divisor  = dvs_ff;

   lcwf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   assign take = (state_ff == S_IDLE) && head_valid;

   always_comb begin
      total_mag = total_ff[WT_W-1] ? WT_W'(-total_ff) : WT_W'(total_ff);
      tt_mag    = tt_ff[TT_W-1] ? TT_W'(-tt_ff) : TT_W'(tt_ff);
      diff      = (SW+1)'(avg_ff) - (SW+1)'(offset_ff);
      diff_mag  = diff[SW] ? (SW+1)'(-diff) : (SW+1)'(diff);
      product   = PW'(diff_mag) * PW'(lcwf_pkg::SCALE_CG);
      q_low     = drsp.quotient[SW-1:0];
   end

   always_comb begin
      state_in  = state_ff;
      store_in  = store_ff;
      ptr_in    = ptr_ff;
      total_in  = total_ff;
      count_in  = count_ff;
      offset_in = offset_ff;
      tt_in     = tt_ff;
      tv_in     = tv_ff;
      own_in    = own_ff;
      avg_in    = avg_ff;
      sign_in   = sign_ff;
      res_w_in  = res_w_ff;
      res_u_in  = res_u_ff;
      start_in  = 1'b0;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      out_valid_in = out_valid_ff && !pop;
      out_w_in  = out_w_ff;
      out_f_in  = out_f_ff;
      out_upd_in = out_upd_ff;

      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               res_w_in = '0;
               res_u_in = 1'b0;
               case (head.kind)
                  lcwf_pkg::KIND_FILTER: begin
                     own_in = head.sample;
                     if (!head.zero) begin
                        // replace the oldest entry and keep the running total
                        store_in[ptr_ff] = head.sample;
                        total_in = total_ff - WT_W'(store_ff[ptr_ff]) + WT_W'(head.sample);
                        ptr_in   = (ptr_ff == PTR_W'(WD - 1)) ? '0 : ptr_ff + 1'b1;
                        if (count_ff < CNT_W'(WD)) begin
                           count_in = count_ff + 1'b1;
                        end
                     end
                     state_in = S_AVG_GO;
                  end
                  lcwf_pkg::KIND_TARE: begin
                     if (!head.zero && tv_ff < TV_W'(TARE_MAX)) begin
                        tt_in = tt_ff + TT_W'(head.sample);
                        tv_in = tv_ff + 1'b1;
                     end
                     state_in = S_EMIT;
                  end
                  lcwf_pkg::KIND_COMMIT: begin
                     if (tv_ff != '0) begin
                        dvd_in   = DW'(tt_mag);
                        dvs_in   = VW'(tv_ff);
                        sign_in  = tt_ff[TT_W-1];
                        start_in = 1'b1;
                        state_in = S_TARE_WAIT;
                     end else begin
                        tt_in    = '0;
                        tv_in    = '0;
                        state_in = S_EMIT;
                     end
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_AVG_GO: begin
            if (count_ff != '0) begin
               dvd_in   = DW'(total_mag);
               dvs_in   = VW'(count_ff);
               sign_in  = total_ff[WT_W-1];
               start_in = 1'b1;
               state_in = S_AVG_WAIT;
            end else begin
               avg_in   = own_ff;
               state_in = S_SCALE;
            end
         end
         S_AVG_WAIT: begin
            if (drsp.done) begin
               avg_in   = sign_ff ? -signed'(q_low) : signed'(q_low);
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            dvd_in   = DW'(product);
            dvs_in   = (cpg == '0) ? VW'(1) : cpg;
            start_in = 1'b1;
            state_in = S_WGT_WAIT;
         end
         S_WGT_WAIT: begin
            if (drsp.done) begin
               res_w_in = (drsp.quotient < DW'(dband)) ? '0 :
                          drsp.quotient[lcwf_pkg::WEIGHT_W-1:0];
               state_in = S_EMIT;
            end
         end
         S_TARE_WAIT: begin
            if (drsp.done) begin
               offset_in = sign_ff ? -signed'(q_low) : signed'(q_low);
               for (int i = 0; i < WD; i++) begin
                  store_in[i] = '0;
               end
               ptr_in   = '0;
               total_in = '0;
               count_in = '0;
               tt_in    = '0;
               tv_in    = '0;
               res_u_in = 1'b1;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!out_valid_ff || pop) begin
               out_valid_in = 1'b1;
               out_w_in     = res_w_ff;
               out_f_in     = lcwf_pkg::FILL_W'(count_ff);
               out_upd_in   = res_u_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      own_ff   <= own_in;
      avg_ff   <= avg_in;
      sign_ff  <= sign_in;
      res_w_ff <= res_w_in;
      res_u_ff <= res_u_in;
      dvd_ff   <= dvd_in;
      dvs_ff   <= dvs_in;
      out_w_ff <= out_w_in;
      out_f_ff <= out_f_in;
      out_upd_ff <= out_upd_in;
      if (reset) begin
         state_ff  <= S_IDLE;
         for (int i = 0; i < WD; i++) begin
            store_ff[i] <= '0;
         end
         ptr_ff    <= '0;
         total_ff  <= '0;
         count_ff  <= '0;
         offset_ff <= '0;
         tt_ff     <= '0;
         tv_ff     <= '0;
         start_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         store_ff  <= store_in;
         ptr_ff    <= ptr_in;
         total_ff  <= total_in;
         count_ff  <= count_in;
         offset_ff <= offset_in;
         tt_ff     <= tt_in;
         tv_ff     <= tv_in;
         start_ff  <= start_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_weight = out_w_ff;
   assign out_fill   = out_f_ff;
   assign out_upd    = out_upd_ff;

   `CHECK_NEXT(a_out_held, clock, reset, out_valid_ff && !pop, out_valid_ff)
   `CHECK_NOW(a_fill_bound, clock, reset, 1'b1, count_ff <= CNT_W'(WD))
   `CHECK_NOW(a_commit_no_weight, clock, reset, out_valid_ff && out_upd_ff, out_w_ff == '0)

endmodule

// File: hdl/load_cell_weight_filter.sv
// Path, push to result: op 0 runs two 34-step serial divisions (average, then scaling),
//   or only the scaling one when the window is empty; op 2 with tare samples runs one;
//   all other items go straight to the result register.
// The back end handles one item at a time and takes no new item until the last is emitted.
// A two-entry input queue and a one-entry result register decouple both sides.
// Reset (synchronous, active high) clears the window, offset, tare sums and queues,
//   and loads counts_per_gram = 450 and deadband_cg = 25.
module load_cell_weight_filter #(
   parameter int WINDOW_DEPTH = 4,
   parameter int TARE_MAX     = 15
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic [lcwf_pkg::OP_W-1:0]              req_op,
   input  logic signed [lcwf_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic [lcwf_pkg::WEIGHT_W-1:0]          rsp_weight_cg,
   output logic [lcwf_pkg::FILL_W-1:0]            rsp_window_fill,
   output logic                                   rsp_offset_updated,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic                                   csr_index,
   input  logic [lcwf_pkg::CFG_W-1:0]             csr_data
);

   logic [lcwf_pkg::CFG_W-1:0] cpg_ff, cpg_in;
   logic [lcwf_pkg::CFG_W-1:0] dband_ff, dband_in;
   logic                       head_valid;
   lcwf_pkg::item_type         head;
   logic                       take;
   logic                       out_valid;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      cpg_in   = cpg_ff;
      dband_in = dband_ff;
      if (csr_valid) begin
         case (csr_index)
            lcwf_pkg::CSR_CPG:   cpg_in   = csr_data;
            lcwf_pkg::CSR_DBAND: dband_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpg_ff   <= lcwf_pkg::RESET_CPG;
         dband_ff <= lcwf_pkg::RESET_DBAND;
      end else begin
         cpg_ff   <= cpg_in;
         dband_ff <= dband_in;
      end
   end

   // front: queue and classify incoming items
   lcwf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .op         (req_op),
      .sample     (req_sample),
      .head_valid (head_valid),
      .head       (head),
      .take       (take)
   );

   // back: window, tare, division and result register
   lcwf_back #(
      .WD       (WINDOW_DEPTH),
      .TARE_MAX (TARE_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .take       (take),
      .cpg        (cpg_ff),
      .dband      (dband_ff),
      .pop        (rsp_pop),
      .out_valid  (out_valid),
      .out_weight (rsp_weight_cg),
      .out_fill   (rsp_window_fill),
      .out_upd    (rsp_offset_updated)
   );

   assign rsp_empty = !out_valid;

endmodule

// File: tb/lcwf_checker.sv
module lcwf_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   input  logic                                 req_full,
   input  logic [lcwf_pkg::OP_W-1:0]            req_op,
   input  logic signed [lcwf_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   input  logic [lcwf_pkg::WEIGHT_W-1:0]        rsp_weight_cg,
   input  logic [lcwf_pkg::FILL_W-1:0]          rsp_window_fill,
   input  logic                                 rsp_offset_updated,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic                                 csr_index,
   input  logic [lcwf_pkg::CFG_W-1:0]           csr_data,
   output int                                   fail_count,
   output int                                   pending
);

   localparam int DEPTH = 4;
   localparam int TMAX  = 15;

   typedef struct packed {
      logic [lcwf_pkg::WEIGHT_W-1:0] weight;
      logic [lcwf_pkg::FILL_W-1:0]   fill;
      logic                          updated;
   } reading_type;

   reading_type readings_due[$];

   longint      win[DEPTH];
   int          wptr, wcount, tvalid;
   longint      wsum, offset, tsum;
   longint      cpg, dband;

   function automatic longint scale_weight(longint own);
      longint avg, diff, w, dv;
      avg  = (wcount > 0) ? wsum / wcount : own;
      diff = avg - offset;
      if (diff < 0) diff = -diff;
      dv = (cpg == 0) ? 1 : cpg;
      w  = (diff * 100) / dv;
      if (w < dband) w = 0;
      return w & 64'h7FFF_FFFF;
   endfunction

   task automatic clear_window();
      for (int i = 0; i < DEPTH; i++) win[i] = 0;
      wptr = 0; wsum = 0; wcount = 0;
   endtask

   task automatic apply_item(logic [lcwf_pkg::OP_W-1:0] op, longint s);
      reading_type r;
      longint      w;
      r = '0;
      if (op == lcwf_pkg::OP_FILTER) begin
         if (s != 0) begin
            wsum = wsum - win[wptr] + s;
            win[wptr] = s;
            wptr = (wptr + 1) % DEPTH;
            if (wcount < DEPTH) wcount++;
         end
         w = scale_weight(s);
         r.weight = w[lcwf_pkg::WEIGHT_W-1:0];
      end else if (op == lcwf_pkg::OP_TARE) begin
         if (s != 0 && tvalid < TMAX) begin
            tsum += s;
            tvalid++;
         end
      end else if (op == lcwf_pkg::OP_COMMIT) begin
         if (tvalid > 0) begin
            offset = tsum / tvalid;
            clear_window();
            r.updated = 1'b1;
         end
         tsum = 0; tvalid = 0;
      end
      r.fill = wcount[lcwf_pkg::FILL_W-1:0];
      readings_due.push_back(r);
   endtask

   always @(posedge clock) begin
      reading_type e;
      if (reset) begin
         clear_window();
         offset = 0; tsum = 0; tvalid = 0;
         cpg = longint'(lcwf_pkg::RESET_CPG); dband = longint'(lcwf_pkg::RESET_DBAND);
         readings_due.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == lcwf_pkg::CSR_CPG) cpg = longint'(csr_data);
            else dband = longint'(csr_data);
         end
         if (!rsp_empty && rsp_pop) begin
            if (readings_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result w=%0d", rsp_weight_cg);
            end else begin
               e = readings_due.pop_front();
               if (e.weight !== rsp_weight_cg || e.fill !== rsp_window_fill ||
                   e.updated !== rsp_offset_updated) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp w=%0d f=%0d u=%0d got w=%0d f=%0d u=%0d",
                        e.weight, e.fill, e.updated,
                        rsp_weight_cg, rsp_window_fill, rsp_offset_updated);
               end
            end
         end
         if (req_push && !req_full) apply_item(req_op, longint'(req_sample));
      end
      pending = readings_due.size();
   end
endmodule

// File: tb/tb_load_cell_weight_filter.sv
module tb_load_cell_weight_filter;

   logic                                 clock = 0, reset = 1;
   logic                                 req_push = 0, req_full;
   logic [lcwf_pkg::OP_W-1:0]            req_op = lcwf_pkg::OP_FILTER;
   logic signed [lcwf_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic                                 rsp_empty, rsp_pop = 0;
   logic [lcwf_pkg::WEIGHT_W-1:0]        rsp_weight_cg;
   logic [lcwf_pkg::FILL_W-1:0]          rsp_window_fill;
   logic                                 rsp_offset_updated;
   logic                                 csr_valid = 0, csr_ready;
   logic                                 csr_index = lcwf_pkg::CSR_CPG;
   logic [lcwf_pkg::CFG_W-1:0]           csr_data = '0;
   int                                   fail_count, pending;
   int                                   send_idle = 35, take_idle = 58;
   bit                                   hold_off = 0;
   longint                               cycles = 0;

   // 20-unit clock period
   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   load_cell_weight_filter dut (.*);

   lcwf_checker check (.*);

   // Pop at random; stall completely during a hold-off stretch.
   always @(posedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= !hold_off && ($urandom_range(99) >= take_idle);
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > 3_000_000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Offer one item after random gaps; hold it until accepted.
   // Push stays high afterwards so the next item can follow at once.
   task automatic send_item(logic [lcwf_pkg::OP_W-1:0] op,
                            logic signed [lcwf_pkg::SAMPLE_W-1:0] s);
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push   <= 1'b1;
      req_op     <= op;
      req_sample <= s;
      do @(posedge clock); while (req_full);
   endtask

   // Drop push, drain, let the block settle, then write one register.
   task automatic write_reg(logic idx, logic [lcwf_pkg::CFG_W-1:0] val);
      req_push <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [lcwf_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(7))
         0: return '0;
         1: return 24'sh7FFFFF;
         2: return 24'sh800000;
         3: return 24'($urandom);
         default: return 24'(int'($urandom_range(20000)) - 10000 + 300000);
      endcase
   endfunction

   // Mostly filter items, with tare items, commits and unused ops mixed in.
   task automatic random_items(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 70) send_item(lcwf_pkg::OP_FILTER, pick_sample());
         else if (k < 88) send_item(lcwf_pkg::OP_TARE, pick_sample());
         else if (k < 97) send_item(lcwf_pkg::OP_COMMIT, pick_sample());
         else send_item(lcwf_pkg::OP_NONE, pick_sample());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, failed reads, empty commit, tare overflow, unused op.
      send_item(lcwf_pkg::OP_FILTER, '0);
      send_item(lcwf_pkg::OP_COMMIT, '0);
      send_item(lcwf_pkg::OP_FILTER, 24'sh7FFFFF);
      send_item(lcwf_pkg::OP_FILTER, 24'sh800000);
      send_item(lcwf_pkg::OP_FILTER, '0);
      send_item(lcwf_pkg::OP_FILTER, 24'sd1000);
      send_item(lcwf_pkg::OP_FILTER, 24'sd2000);
      send_item(lcwf_pkg::OP_FILTER, -24'sd5);
      send_item(lcwf_pkg::OP_NONE, 24'sd77);
      for (int i = 0; i < 17; i++)
         send_item(lcwf_pkg::OP_TARE, (i == 3) ? 24'sd0 : 24'(-1000 - i));
      send_item(lcwf_pkg::OP_COMMIT, '0);
      send_item(lcwf_pkg::OP_FILTER, '0);

      // Extreme settings: largest divisor, zero divisor, tiny and huge deadband.
      write_reg(lcwf_pkg::CSR_CPG, 16'hFFFF);
      write_reg(lcwf_pkg::CSR_DBAND, 16'd0);
      random_items(120);
      write_reg(lcwf_pkg::CSR_CPG, 16'd0);
      random_items(120);
      write_reg(lcwf_pkg::CSR_CPG, 16'd1);
      write_reg(lcwf_pkg::CSR_DBAND, 16'hFFFF);
      random_items(100);
      write_reg(lcwf_pkg::CSR_CPG, lcwf_pkg::RESET_CPG);
      write_reg(lcwf_pkg::CSR_DBAND, 16'd3);
      random_items(200);

      // Hold off the receiver for a counted stretch so the queues fill and push stalls.
      fork
         begin
            hold_off = 1;
            repeat (600) @(posedge clock);
            hold_off = 0;
         end
         begin
            random_items(8);
            req_push <= 1'b0;
         end
      join
      // Pause the sender until every item is back.
      while (pending != 0) @(posedge clock);

      send_idle = 58; take_idle = 35;
      random_items(220);
      send_idle = 0;  take_idle = 0;
      random_items(220);
      req_push <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
